### sv/assert_macros.svh
// Assertion macros used by the top level of the token splitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property at every rising edge of clk_i outside reset.
`define TTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tts assertion failed");
// Check that a condition in the next cycle follows from a condition now.
`define TTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tts assertion failed");
`else
`define TTS_ASSERT(lbl, prop)
`define TTS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/tts_pkg.sv
// Types, character constants and classifiers for the token splitter.
`timescale 1ns / 1ps
`default_nettype none
package tts_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE        = 2'd0,
    MODE_TOKEN       = 2'd1,
    MODE_COMMENT     = 2'd2,
    MODE_TOKEN_SLASH = 2'd3
  } scan_mode_e;

  localparam int unsigned MaxResults = 3;
  localparam int unsigned ResIdxW    = 2;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  localparam logic [7:0] ChOpen  = 8'h7B;
  localparam logic [7:0] ChClose = 8'h7D;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChCr    = 8'h0D;

  // One result byte.
  typedef struct packed {
    logic [7:0] tok_byte;
    logic       last;
    logic       brace;
  } res_t;

  // All results caused by one input byte; count is never zero in the queue.
  typedef struct packed {
    res_t [MaxResults-1:0] res;
    logic [ResIdxW-1:0]    count;
  } bundle_t;

  typedef struct packed {
    logic    push;
    bundle_t data;
  } q_wr_t;

  typedef struct packed {
    logic    valid;
    bundle_t data;
  } q_rd_t;

  function automatic logic is_sep(logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A) ||
           (c == 8'h2C) || (c == 8'h3B) || (c == 8'h22) || (c == 8'h00);
  endfunction

  function automatic logic is_brace(logic [7:0] c);
    return (c == ChOpen) || (c == ChClose);
  endfunction

endpackage
`default_nettype wire

### sv/tts_front.sv
// Front end: scans one byte per transfer and builds its bundle of results.
`timescale 1ns / 1ps
`default_nettype none
module tts_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    text_byte_i,
  input  logic          buffer_end_i,
  output logic          in_stall_o,
  input  logic          q_full_i,
  output tts_pkg::q_wr_t q_wr_o
);
  import tts_pkg::*;

  scan_mode_e mode_q, mode_d;
  logic [7:0] held_q, held_d;
  logic       hv_q, hv_d;
  logic       accept;
  bundle_t    bnd;
  logic       do_tok, do_idle;
  logic [7:0] tok_x;

  function automatic bundle_t add_res(bundle_t b, logic [7:0] v, logic l, logic br);
    bundle_t r;
    r = b;
    if (b.count != ResIdxW'(MaxResults)) begin
      r.res[b.count] = '{tok_byte: v, last: l, brace: br};
      r.count        = b.count + ResIdxW'(1);
    end
    return r;
  endfunction

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    bnd     = '0;
    mode_d  = mode_q;
    held_d  = held_q;
    hv_d    = hv_q;
    do_tok  = 1'b0;
    do_idle = 1'b0;
    tok_x   = held_q;
    case (mode_q)
      MODE_COMMENT: begin
        if (text_byte_i == ChCr) begin
          mode_d = MODE_IDLE;
          held_d = '0;
          hv_d   = 1'b0;
        end
      end
      MODE_TOKEN: begin
        do_tok = 1'b1;
      end
      MODE_TOKEN_SLASH: begin
        if (text_byte_i == ChSlash) begin
          bnd    = add_res(bnd, held_q, 1'b1, 1'b0);
          mode_d = MODE_COMMENT;
          held_d = '0;
          hv_d   = 1'b0;
        end else begin
          bnd    = add_res(bnd, held_q, 1'b0, 1'b0);
          tok_x  = ChSlash;
          do_tok = 1'b1;
        end
      end
      default: begin
        if (hv_q) begin
          held_d = '0;
          hv_d   = 1'b0;
          if (text_byte_i == ChSlash) begin
            mode_d = MODE_COMMENT;
          end else begin
            do_idle = 1'b1;
          end
        end else begin
          do_idle = 1'b1;
        end
      end
    endcase

    // Pending token byte followed by the new byte.
    if (do_tok) begin
      if (is_sep(text_byte_i)) begin
        bnd    = add_res(bnd, tok_x, 1'b1, 1'b0);
        mode_d = MODE_IDLE;
        held_d = '0;
        hv_d   = 1'b0;
      end else if (is_brace(text_byte_i)) begin
        bnd    = add_res(bnd, tok_x, 1'b1, 1'b0);
        bnd    = add_res(bnd, text_byte_i, 1'b1, 1'b1);
        mode_d = MODE_IDLE;
        held_d = '0;
        hv_d   = 1'b0;
      end else if (text_byte_i == ChSlash) begin
        mode_d = MODE_TOKEN_SLASH;
        held_d = tok_x;
        hv_d   = 1'b1;
      end else begin
        bnd    = add_res(bnd, tok_x, 1'b0, 1'b0);
        mode_d = MODE_TOKEN;
        held_d = text_byte_i;
        hv_d   = 1'b1;
      end
    end

    // New byte between tokens with nothing held.
    if (do_idle) begin
      if (is_sep(text_byte_i)) begin
        // drop
      end else if (text_byte_i == ChSlash) begin
        held_d = text_byte_i;
        hv_d   = 1'b1;
      end else if (is_brace(text_byte_i)) begin
        bnd = add_res(bnd, text_byte_i, 1'b1, 1'b1);
      end else begin
        mode_d = MODE_TOKEN;
        held_d = text_byte_i;
        hv_d   = 1'b1;
      end
    end

    // Flush at the end of the buffer and return to the reset state.
    if (buffer_end_i) begin
      if (mode_d == MODE_TOKEN) begin
        bnd = add_res(bnd, held_d, 1'b1, 1'b0);
      end else if (mode_d == MODE_TOKEN_SLASH) begin
        bnd = add_res(bnd, held_d, 1'b0, 1'b0);
        bnd = add_res(bnd, ChSlash, 1'b1, 1'b0);
      end
      mode_d = MODE_IDLE;
      held_d = '0;
      hv_d   = 1'b0;
    end
  end

  assign q_wr_o.push = accept && (bnd.count != '0);
  assign q_wr_o.data = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      held_q <= '0;
      hv_q   <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      held_q <= held_d;
      hv_q   <= hv_d;
    end
  end

endmodule
`default_nettype wire

### sv/tts_queue.sv
// Short queue of result bundles between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module tts_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tts_pkg::q_wr_t q_wr_i,
  output logic           q_full_o,
  input  logic           q_pop_i,
  output tts_pkg::q_rd_t q_rd_o
);
  import tts_pkg::*;

  bundle_t          entries_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q, count_d;
  logic             push, pop;

  assign q_full_o = (count_q == (QPtrW+1)'(QueueDepth));
  assign push     = q_wr_i.push && !q_full_o;
  assign pop      = q_pop_i && (count_q != '0);

  assign q_rd_o.valid = (count_q != '0);
  assign q_rd_o.data  = entries_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + (QPtrW+1)'(1);
    end else if (pop && !push) begin
      count_d = count_q - (QPtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= q_wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      count_q <= count_d;
    end
  end

endmodule
`default_nettype wire

### sv/tts_back.sv
// Back end: walks each bundle into the output register one result per cycle while out_stall_i is low.
`timescale 1ns / 1ps
`default_nettype none
module tts_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tts_pkg::q_rd_t q_rd_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     token_byte_o,
  output logic           token_last_o,
  output logic           brace_token_o,
  output logic           run_last_o
);
  import tts_pkg::*;

  logic [ResIdxW-1:0] sub_q, sub_d;
  logic               ov_q, ov_d;
  logic [7:0]         byte_q;
  logic               last_q, brace_q, run_q;
  logic               load, run_end;
  res_t               cur;

  assign cur     = q_rd_i.data.res[sub_q];
  assign run_end = (sub_q == (q_rd_i.data.count - ResIdxW'(1)));
  assign load    = q_rd_i.valid && (!ov_q || !out_stall_i);
  assign q_pop_o = load && run_end;

  always_comb begin
    sub_d = sub_q;
    ov_d  = ov_q;
    if (load) begin
      sub_d = run_end ? '0 : sub_q + ResIdxW'(1);
      ov_d  = 1'b1;
    end else if (!out_stall_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      sub_q <= sub_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= cur.tok_byte;
      last_q  <= cur.last;
      brace_q <= cur.brace;
      run_q   <= run_end;
    end
  end

  assign out_valid_o   = ov_q;
  assign token_byte_o  = byte_q;
  assign token_last_o  = last_q;
  assign brace_token_o = brace_q;
  assign run_last_o    = run_q;

endmodule
`default_nettype wire

### sv/text_token_splitter_top.sv
// Top level of the delimiter tokenizer with line comments.
//
//   channel  direction  handshake                  payload
//   input    in         in_valid_i / in_stall_o    text_byte_i, buffer_end_i
//   output   out        out_valid_o / out_stall_i  token_byte_o, token_last_o,
//                                                   brace_token_o, run_last_o
//
// The front end takes one byte per cycle unless the queue is full; each byte yields zero to three results.
// The back end issues one result per cycle while out_stall_i is low, so output bandwidth
// sets the sustained rate; a byte with no results pushes nothing into the queue.
// An input byte's results pass through a queue entry and then the output register.
// Reset clears the scanner state, queue pointers and count, output valid and result index.
// The input stalls only while the four-bundle queue is full.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module text_token_splitter_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       buffer_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] token_byte_o,
  output logic       token_last_o,
  output logic       brace_token_o,
  output logic       run_last_o
);
  import tts_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  // Classify each byte, advance the scan state and build the result bundle.
  tts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .text_byte_i  (text_byte_i),
    .buffer_end_i (buffer_end_i),
    .in_stall_o   (in_stall_o),
    .q_full_i     (q_full),
    .q_wr_o       (q_wr)
  );

  // Hold bundles so a stalled output does not stop scanning at once.
  tts_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_wr_i   (q_wr),
    .q_full_o (q_full),
    .q_pop_i  (q_pop),
    .q_rd_o   (q_rd)
  );

  // Drain bundles one result per transfer; mark the last of each bundle.
  tts_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_rd_i        (q_rd),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_byte_o  (token_byte_o),
    .token_last_o  (token_last_o),
    .brace_token_o (brace_token_o),
    .run_last_o    (run_last_o)
  );

  // A brace always forms a one-byte token.
  `TTS_ASSERT(a_brace_is_last, !(out_valid_o && brace_token_o) || token_last_o)
  // Mid-bundle the next result is already queued and follows without a gap.
  `TTS_ASSERT_NEXT(a_run_continues, out_valid_o && !out_stall_i && !run_last_o, out_valid_o)
  // The front end never pushes into a full queue.
  `TTS_ASSERT(a_no_push_full, !(q_wr.push && q_full))

endmodule
`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the delimiter tokenizer with line comments.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import tts_pkg::*;

  // One token byte as seen on the output channel.
  typedef struct packed {
    logic [7:0] tok_byte;
    logic       last;
    logic       brace;
    logic       run_last;
  } tok_beat_t;

  // One directed stimulus row. Rows with hand_exp set carry their expected
  // result inline: none, or a single byte that closes its token.
  typedef struct packed {
    logic [7:0] text;
    logic       buf_end;
    logic       hand_exp;
    logic       hand_cnt;
    logic [7:0] hand_byte;
    logic       hand_brace;
  } stim_row_t;

  localparam int NumDirected   = 24;
  localparam int RandomPerPass = 22;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall_o;
  logic [7:0] text_byte = 8'h00;
  logic       buffer_end = 1'b0;
  logic       out_valid_o;
  logic       out_stall = 1'b0;
  logic [7:0] token_byte_o;
  logic       token_last_o;
  logic       brace_token_o;
  logic       run_last_o;

  // Split predictor state.
  scan_mode_e scan_state = MODE_IDLE;
  logic [7:0] pend_byte = 8'h00;
  logic       pend_valid = 1'b0;

  tok_beat_t  step_beats[$];
  tok_beat_t  pending_tokens[$];
  stim_row_t  dir_rows[NumDirected];

  int idle_pct  = 0;
  int stall_pct = 0;
  int errors    = 0;
  int n_bytes   = 0;
  int n_checked = 0;

  text_token_splitter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .text_byte_i   (text_byte),
    .buffer_end_i  (buffer_end),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .token_byte_o  (token_byte_o),
    .token_last_o  (token_last_o),
    .brace_token_o (brace_token_o),
    .run_last_o    (run_last_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #200000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic logic is_delim(logic [7:0] c);
    case (c)
      8'h20, 8'h09, 8'h0D, 8'h0A, 8'h2C, 8'h3B, 8'h22, 8'h00: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_curly(logic [7:0] c);
    return (c == ChOpen) || (c == ChClose);
  endfunction

  // A single byte can never yield more than three results.
  function automatic void put_beat(logic [7:0] b, logic last, logic brace);
    if (step_beats.size() < 3) step_beats.push_back('{b, last, brace, 1'b0});
  endfunction

  function automatic void clear_scan();
    scan_state = MODE_IDLE;
    pend_byte  = 8'h00;
    pend_valid = 1'b0;
  endfunction

  // Byte between tokens with nothing pending.
  function automatic void open_token(logic [7:0] c);
    if (is_delim(c)) return;
    if (c == ChSlash) begin
      pend_byte  = c;
      pend_valid = 1'b1;
    end else if (is_curly(c)) begin
      put_beat(c, 1'b1, 1'b1);
    end else begin
      scan_state = MODE_TOKEN;
      pend_byte  = c;
      pend_valid = 1'b1;
    end
  endfunction

  // Resolve pending token byte x against the next byte c.
  function automatic void extend_token(logic [7:0] x, logic [7:0] c);
    if (is_delim(c)) begin
      put_beat(x, 1'b1, 1'b0);
      clear_scan();
    end else if (is_curly(c)) begin
      put_beat(x, 1'b1, 1'b0);
      put_beat(c, 1'b1, 1'b1);
      clear_scan();
    end else if (c == ChSlash) begin
      scan_state = MODE_TOKEN_SLASH;
      pend_byte  = x;
      pend_valid = 1'b1;
    end else begin
      put_beat(x, 1'b0, 1'b0);
      scan_state = MODE_TOKEN;
      pend_byte  = c;
      pend_valid = 1'b1;
    end
  endfunction

  // Advance the predictor by one accepted byte; results land in step_beats.
  function automatic void split_byte(logic [7:0] c, logic flush);
    logic [7:0] h;
    h = pend_byte;
    step_beats.delete();
    case (scan_state)
      MODE_COMMENT: begin
        if (c == ChCr) clear_scan();
      end
      MODE_TOKEN: extend_token(h, c);
      MODE_TOKEN_SLASH: begin
        if (c == ChSlash) begin
          put_beat(h, 1'b1, 1'b0);
          scan_state = MODE_COMMENT;
          pend_byte  = 8'h00;
          pend_valid = 1'b0;
        end else begin
          put_beat(h, 1'b0, 1'b0);
          extend_token(ChSlash, c);
        end
      end
      default: begin
        if (pend_valid) begin
          pend_byte  = 8'h00;
          pend_valid = 1'b0;
          if (c == ChSlash) scan_state = MODE_COMMENT;
          else open_token(c);
        end else begin
          open_token(c);
        end
      end
    endcase
    // Buffer end flushes whatever token is open and forgets any comment.
    if (flush) begin
      if (scan_state == MODE_TOKEN) begin
        put_beat(pend_byte, 1'b1, 1'b0);
      end else if (scan_state == MODE_TOKEN_SLASH) begin
        put_beat(pend_byte, 1'b0, 1'b0);
        put_beat(ChSlash, 1'b1, 1'b0);
      end
      clear_scan();
    end
    if (step_beats.size() > 0) step_beats[step_beats.size()-1].run_last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------
  // Offer one byte, hold it until the transfer, then queue its results.
  task automatic send_byte(input logic [7:0] b, input logic flush, input logic hand_exp,
                           input logic hand_cnt, input logic [7:0] hand_byte,
                           input logic hand_brace);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    text_byte  <= b;
    buffer_end <= flush;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_bytes++;
    split_byte(b, flush);
    if (hand_exp) begin
      if (hand_cnt) pending_tokens.push_back('{hand_byte, 1'b1, hand_brace, 1'b1});
    end else begin
      foreach (step_beats[i]) pending_tokens.push_back(step_beats[i]);
    end
  endtask

  // Lowercase letters (the largest share) with separators, slashes, braces and CR mixed in,
  // plus a share of arbitrary bytes so every bit toggles.
  function automatic logic [7:0] pick_text();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'h61 + 8'($urandom_range(0, 25));
    if (r < 55) begin
      case ($urandom_range(0, 7))
        0: return 8'h20;
        1: return 8'h09;
        2: return 8'h0A;
        3: return 8'h2C;
        4: return 8'h3B;
        5: return 8'h22;
        6: return 8'h00;
        default: return 8'h0D;
      endcase
    end
    if (r < 68) return ChSlash;
    if (r < 76) return ($urandom_range(0, 1) != 0) ? ChOpen : ChClose;
    if (r < 81) return ChCr;
    return 8'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------
  // Output side: check each transfer, then pick the next stall.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (pending_tokens.size() == 0) begin
          $error("unexpected result: token_byte %h", token_byte_o);
          errors++;
        end else begin
          tok_beat_t want;
          want = pending_tokens.pop_front();
          n_checked++;
          if (token_byte_o !== want.tok_byte) begin
            $error("token_byte: expected %h, got %h", want.tok_byte, token_byte_o);
            errors++;
          end
          if (token_last_o !== want.last) begin
            $error("token_last: expected %b, got %b", want.last, token_last_o);
            errors++;
          end
          if (brace_token_o !== want.brace) begin
            $error("brace_token: expected %b, got %b", want.brace, brace_token_o);
            errors++;
          end
          if (run_last_o !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, run_last_o);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    int idle_set[4];
    int stall_set[4];
    // text, end, hand-typed, count, byte, brace
    dir_rows = '{
      '{8'h7B, 1'b0, 1'b1, 1'b1, 8'h7B, 1'b1},  // lone open brace
      '{8'h7D, 1'b0, 1'b1, 1'b1, 8'h7D, 1'b1},  // lone close brace
      '{8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b0},  // top byte, flushed at once
      '{8'h00, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0},  // NUL at buffer end: nothing
      '{8'h61, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},  // a
      '{8'h2F, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},  // a/
      '{8'h7B, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},  // a/{ : three results
      '{8'h78, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},  // x
      '{8'h2F, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h2F, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},  // x// ends token, opens comment
      '{8'h71, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},  // swallowed by comment
      '{8'h0D, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},  // CR closes comment
      '{8'h2F, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},  // lone slash between tokens
      '{8'h6B, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},  // slash dropped, k starts
      '{8'h2F, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h20, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},  // trailing slash kept
      '{8'h7A, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h2F, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},  // slash flushed at buffer end
      '{8'h80, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h2F, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h2F, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},  // comment cut by buffer end
      '{8'h74, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h7D, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},  // brace right after token
      '{8'h2F, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}   // pending slash flushed: nothing
    };
    idle_set  = '{0, 82, 0, 6};
    stall_set = '{0, 0, 82, 6};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_byte(dir_rows[i].text, dir_rows[i].buf_end, dir_rows[i].hand_exp,
                dir_rows[i].hand_cnt, dir_rows[i].hand_byte, dir_rows[i].hand_brace);

    // Random text under each idling pattern in turn.
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      for (int k = 0; k < RandomPerPass; k++)
        send_byte(pick_text(), ($urandom_range(0, 19) == 0), 1'b0, 1'b0, 8'h00, 1'b0);
    end
    in_valid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d text bytes (directed cases, then random text under four idle/stall mixes).",
             n_bytes);
    $display("Checked %0d token bytes field by field.", n_checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
+incdir+sv
sv/tts_pkg.sv
sv/tts_front.sv
sv/tts_queue.sv
sv/tts_back.sv
sv/text_token_splitter_top.sv
sim/tb.sv
